[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the moving window deviation checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/mwsd_pkg.sv]
// ----------------------------------------------------------------------------
// mwsd_pkg
// Fixed field widths, constants and shared types of the moving window
// standard deviation block.
// ----------------------------------------------------------------------------
package mwsd_pkg;

	// Field widths fixed by the interface.
	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 6;
	localparam int STD_W    = 23;

	// Half window after reset.
	localparam logic [CFG_W-1:0] HALF_RESET = 6'd4;

	// Zero bit pairs appended to the radicand: eight fraction bits of the root.
	localparam int FRAC_PAIRS = 8;

	// Status of the root and divide unit.
	typedef struct packed {
		logic             done;
		logic [STD_W-1:0] quot;
	} rd_stat_t;

endpackage

[rtl/moving_window_std_dev.sv]
// ----------------------------------------------------------------------------
// moving_window_std_dev
// Population standard deviation over a sliding window of 2*H samples.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the item channel (item_valid, item_stall, sample,
// is_last); results leave on the result channel (result_valid,
// result_stall, std_value, last_out). A beat moves when valid is high and
// stall is low. cfg_wr_en writes half_window from cfg_wr_data; the user
// keeps such writes to while idle, as the block does not enforce it.
// Every write also restarts the signal. One item is worked on at a time.
// Each item makes one window push, the first of a signal H+1 pushes, and
// a last item H-1 more. A push passes the states S_RD, S_SQ and S_UPD; a
// push that fills the window adds a result through S_START, S_MUL, S_SUB,
// S_ROOT and S_OUT. S_MUL squares the sum bit-serially over SUM_W =
// sample bits + log2 of the line depth, and S_ROOT takes ROOT_STEPS =
// half the radicand width + 8 steps (two-bit root digits).
// The sample line is a memory of 2*MAX_HALF_WINDOW entries read through a
// register; a fill count covers entries not yet written, so reset needs no
// clearing pass. Reset returns H to 4 and empties the window.
// A stalled result holds in the output register; the block waits there
// before it starts the next push.
// ----------------------------------------------------------------------------
module moving_window_std_dev #(
	parameter int MAX_HALF_WINDOW = 32,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [mwsd_pkg::CFG_W-1:0]    cfg_wr_data,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [mwsd_pkg::SAMPLE_W-1:0] sample,
	input  logic                          is_last,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [mwsd_pkg::STD_W-1:0]    std_value,
	output logic                          last_out
);

	localparam int LINE_DEPTH = 2 * MAX_HALF_WINDOW;
	localparam int SB   = (SAMPLE_BITS < mwsd_pkg::SAMPLE_W) ? SAMPLE_BITS
	                                                          : mwsd_pkg::SAMPLE_W;
	localparam int AB   = $clog2(LINE_DEPTH);
	localparam int HB   = $clog2(MAX_HALF_WINDOW + 1);
	localparam int WB   = HB + 1;
	localparam int SUMW = SB + AB;
	localparam int SQW  = 2 * SB + AB;
	localparam int HQW  = SQW + HB;
	localparam int AW   = HQW + 1;
	localparam int SSW  = 2 * SUMW;
	localparam int CW   = (AW > SSW) ? AW : SSW;
	localparam int RADW = 2 * ((CW + 1) / 2);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_RD    = 9'b000000010,
		S_SQ    = 9'b000000100,
		S_UPD   = 9'b000001000,
		S_START = 9'b000010000,
		S_MUL   = 9'b000100000,
		S_SUB   = 9'b001000000,
		S_ROOT  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t                      state_q;
	logic [mwsd_pkg::CFG_W-1:0]  hw_q;
	logic [WB-1:0]               seen_q;
	logic [WB-1:0]               cnt_q;
	logic [AB-1:0]               wp_q;
	logic                        fin_q;
	logic [SUMW-1:0]             sum_q;
	logic [SQW-1:0]              sq_q;
	logic                        res_valid_q;

	logic [SB-1:0]               s_q;
	logic                        last_q;
	logic [2*SB-1:0]             s_sq_q;
	logic [SB-1:0]               rd_q;
	logic [SB-1:0]               old_q;
	logic [2*SB-1:0]             old_sq_q;
	logic [mwsd_pkg::STD_W-1:0]  std_q;
	logic                        last_out_q;

	logic [SB-1:0]               line_mem [LINE_DEPTH];

	logic [mwsd_pkg::CFG_W-1:0]  h_wide;
	logic [HB-1:0]               h_eff;
	logic [WB-1:0]               w;
	logic                        accept;
	logic                        full;
	logic [AB:0]                 rd_sum;
	logic [AB-1:0]               rd_addr;
	logic [2*SB-1:0]             rd_sq;
	logic [2*SB-1:0]             s_sq;
	logic [SUMW-1:0]             sum_nx;
	logic [SQW-1:0]              sq_nx;
	logic [WB-1:0]               seen_nx;
	logic [AB-1:0]               wp_nx;
	logic [WB-1:0]               push_cnt;
	logic                        mul_start;
	logic [SSW-1:0]              ss_prod;
	logic                        ss_done;
	logic [HQW-1:0]              hq_prod;
	logic                        hq_done;
	logic [RADW-1:0]             a_ext;
	logic [RADW-1:0]             b_ext;
	logic [RADW-1:0]             radicand;
	logic                        rd_start;
	mwsd_pkg::rd_stat_t          rd_stat;

	// Effective half window: zero acts as one, large values saturate.
	always_comb begin
		if (hw_q == '0) begin
			h_wide = mwsd_pkg::CFG_W'(1);
		end else if (hw_q > mwsd_pkg::CFG_W'(MAX_HALF_WINDOW)) begin
			h_wide = mwsd_pkg::CFG_W'(MAX_HALF_WINDOW);
		end else begin
			h_wide = hw_q;
		end
		h_eff = h_wide[HB-1:0];
		w     = {h_eff, 1'b0};
	end

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != S_IDLE);
	assign full       = (seen_q >= w);

	// Pushes owed for the accepted sample.
	always_comb begin
		push_cnt = WB'(1);
		if (seen_q == '0) begin
			push_cnt = push_cnt + WB'(h_eff);
		end
		if (is_last) begin
			push_cnt = push_cnt + WB'(h_eff) - WB'(1);
		end
	end

	// Address of the entry that leaves the window: w pushes back, wrapped.
	always_comb begin
		rd_sum = {1'b0, wp_q} + (AB+1)'(LINE_DEPTH) - (AB+1)'(w);
		if (rd_sum >= (AB+1)'(LINE_DEPTH)) begin
			rd_sum = rd_sum - (AB+1)'(LINE_DEPTH);
		end
		rd_addr = rd_sum[AB-1:0];
	end

	// Squares of the incoming and the leaving sample.
	assign s_sq  = s_q * s_q;
	assign rd_sq = rd_q * rd_q;

	// Running sums after the push.
	always_comb begin
		sum_nx  = sum_q - SUMW'(old_q) + SUMW'(s_q);
		sq_nx   = sq_q - SQW'(old_sq_q) + SQW'(s_sq_q);
		seen_nx = (seen_q < w) ? seen_q + WB'(1) : seen_q;
		wp_nx   = (wp_q == AB'(LINE_DEPTH - 1)) ? '0 : wp_q + AB'(1);
	end

	// Window line memory with a registered read, used in the cycle after.
	always_ff @(posedge clk) begin
		if (state_q == S_SQ) begin
			line_mem[wp_q] <= s_q;
		end
		rd_q <= line_mem[rd_addr];
	end

	// Sequencer and stream state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hw_q        <= mwsd_pkg::HALF_RESET;
			seen_q      <= '0;
			cnt_q       <= '0;
			wp_q        <= '0;
			fin_q       <= 1'b0;
			sum_q       <= '0;
			sq_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// The output register fills from the last stage and empties when taken.
			if (state_q == S_OUT && (!res_valid_q || !result_stall)) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				hw_q   <= cfg_wr_data;
				seen_q <= '0;
				sum_q  <= '0;
				sq_q   <= '0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q   <= push_cnt;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_SQ;
				end
				S_SQ: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					cnt_q <= cnt_q - WB'(1);
					fin_q <= (cnt_q == WB'(1));
					wp_q  <= wp_nx;
					if (seen_nx == w) begin
						sum_q   <= sum_nx;
						sq_q    <= sq_nx;
						seen_q  <= seen_nx;
						state_q <= S_START;
					end else if (cnt_q == WB'(1) && last_q) begin
						sum_q   <= '0;
						sq_q    <= '0;
						seen_q  <= '0;
						state_q <= S_IDLE;
					end else begin
						sum_q   <= sum_nx;
						sq_q    <= sq_nx;
						seen_q  <= seen_nx;
						state_q <= (cnt_q == WB'(1)) ? S_IDLE : S_RD;
					end
				end
				S_START: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (ss_done && hq_done) begin
						state_q <= S_SUB;
					end
				end
				S_SUB: begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (rd_stat.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!res_valid_q || !result_stall) begin
						if (fin_q) begin
							if (last_q) begin
								sum_q  <= '0;
								sq_q   <= '0;
								seen_q <= '0;
							end
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Sample, squares and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			s_q    <= sample[SB-1:0];
			last_q <= is_last;
		end
		if (state_q == S_RD) begin
			s_sq_q <= s_sq;
		end
		if (state_q == S_SQ) begin
			old_q    <= full ? rd_q : '0;
			old_sq_q <= full ? rd_sq : '0;
		end
		if (state_q == S_OUT && (!res_valid_q || !result_stall)) begin
			std_q      <= rd_stat.quot;
			last_out_q <= last_q && fin_q;
		end
	end

	// Bit-serial products: sum squared, and half window times square sum.
	assign mul_start = (state_q == S_START);

	mwsd_serial_mul #(
		.A_W (SUMW),
		.B_W (SUMW)
	) u_mul_ss (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (sum_q),
		.b      (sum_q),
		.prod   (ss_prod),
		.done   (ss_done)
	);

	mwsd_serial_mul #(
		.A_W (SQW),
		.B_W (HB)
	) u_mul_hq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (sq_q),
		.b      (h_eff),
		.prod   (hq_prod),
		.done   (hq_done)
	);

	// Radicand W*Q - S*S, clamped at zero.
	always_comb begin
		a_ext = RADW'({hq_prod, 1'b0});
		b_ext = RADW'(ss_prod);
		radicand = (a_ext > b_ext) ? a_ext - b_ext : '0;
	end

	assign rd_start = (state_q == S_SUB);

	mwsd_root_div #(
		.RAD_W (RADW),
		.DIV_W (WB)
	) u_root_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rd_start),
		.radicand (radicand),
		.divisor  (w),
		.stat     (rd_stat)
	);

	assign result_valid = res_valid_q;
	assign std_value    = std_q;
	assign last_out     = last_out_q;

endmodule

[rtl/mwsd_serial_mul.sv]
// ----------------------------------------------------------------------------
// mwsd_serial_mul
// Shift-and-add multiplier that takes one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mwsd_serial_mul #(
	parameter int A_W = 22,
	parameter int B_W = 22
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [A_W-1:0]   a,
	input  logic [B_W-1:0]   b,
	output logic [A_W+B_W-1:0] prod,
	output logic             done
);

	localparam int PW = A_W + B_W;
	localparam int CB = $clog2(B_W + 1);

	logic [PW-1:0]  mcand_q;
	logic [B_W-1:0] mplier_q;
	logic [PW-1:0]  acc_q;
	logic [CB-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;

	// Step control: one multiplier bit is consumed in every busy cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CB'(1);
			if (cnt_q == CB'(B_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Operand shift registers and the accumulator.
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= PW'(a);
			mplier_q <= b;
			acc_q    <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[PW-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[B_W-1:1]};
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

[rtl/mwsd_root_div.sv]
// ----------------------------------------------------------------------------
// mwsd_root_div
// Digit-serial square root, two radicand bits per cycle, with each new root
// bit fed straight into a restoring divider by the window length.
// ----------------------------------------------------------------------------
module mwsd_root_div #(
	parameter int RAD_W = 46,
	parameter int DIV_W = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [RAD_W-1:0]    radicand,
	input  logic [DIV_W-1:0]    divisor,
	output mwsd_pkg::rd_stat_t  stat
);

	localparam int STEPS = RAD_W / 2 + mwsd_pkg::FRAC_PAIRS;
	localparam int RW    = STEPS;
	localparam int TW    = RW + 3;
	localparam int CB    = $clog2(STEPS + 1);

	logic [RAD_W-1:0]            rad_q;
	logic [RW:0]                 rem_q;
	logic [RW-1:0]               root_q;
	logic [DIV_W-1:0]            dr_q;
	logic [mwsd_pkg::STD_W-1:0]  quot_q;
	logic [CB-1:0]               cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [TW-1:0]    rem_shift;
	logic [TW-1:0]    trial;
	logic [TW-1:0]    rem_diff;
	logic             root_bit;
	logic [DIV_W:0]   dr_shift;
	logic [DIV_W:0]   dr_diff;
	logic             quot_bit;

	// One root digit: bring down the next bit pair and try 4*root+1.
	always_comb begin
		rem_shift = {rem_q, rad_q[RAD_W-1 -: 2]};
		trial     = {1'b0, root_q, 2'b01};
		root_bit  = (rem_shift >= trial);
		rem_diff  = rem_shift - trial;
	end

	// One quotient bit: the new root bit is the next dividend bit.
	always_comb begin
		dr_shift = {dr_q, root_bit};
		quot_bit = (dr_shift >= {1'b0, divisor});
		dr_diff  = dr_shift - {1'b0, divisor};
	end

	// Step control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CB'(1);
			if (cnt_q == CB'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Radicand shift line, partial remainder, root and quotient.
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
			dr_q   <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= root_bit ? rem_diff[RW:0] : rem_shift[RW:0];
			root_q <= {root_q[RW-2:0], root_bit};
			dr_q   <= quot_bit ? dr_diff[DIV_W-1:0] : dr_shift[DIV_W-1:0];
			quot_q <= {quot_q[mwsd_pkg::STD_W-2:0], quot_bit};
		end
	end

	assign stat.done = done_q;
	assign stat.quot = quot_q;

endmodule

[rtl/mwsd_checker.sv]
// ----------------------------------------------------------------------------
// mwsd_checker
// Port-level checks of the moving window deviation block, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mwsd_assertions (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_stall,
	input logic                       result_valid,
	input logic                       result_stall,
	input logic [mwsd_pkg::STD_W-1:0] std_value,
	input logic                       last_out
);

	// A stalled result beat stays put.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, result_valid && result_stall,
		result_valid && $stable(std_value) && $stable(last_out))

	// Every accepted sample keeps the block busy for at least one push.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, item_valid && !item_stall, item_stall)

	// A new result only comes out of work on an accepted sample.
	`ASSERT_IMPL(a_result_from_work, clk, arst_n, $rose(result_valid), $past(item_stall))

	// The final result of a signal leaves the block ready for the next one.
	`ASSERT_IMPL(a_idle_after_last, clk, arst_n, $rose(result_valid) && last_out, !item_stall)

endmodule

bind moving_window_std_dev mwsd_assertions u_mwsd_assertions (.*);
